// File: hdl/key_matrix_midi_note_events_macros.svh
// assertion macros for the key matrix note event checker
`ifndef KEY_MATRIX_MIDI_NOTE_EVENTS_MACROS_SVH
`define KEY_MATRIX_MIDI_NOTE_EVENTS_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define KMNE_CHK_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define KMNE_CHK_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// what must hold in the cycle after reset is sampled low
`define KMNE_CHK_RST(label, post, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/kmne_pkg.sv
// shared types, constants and note arithmetic for the key matrix note event block
`timescale 1ns / 1ps
`default_nettype none

package kmne_pkg;

  localparam int COL_W    = 4;
  localparam int SENSE_W  = 4;
  localparam int ROW_MAX  = 8;
  localparam int BYTE_W   = 8;
  localparam int VEL_W    = 7;
  localparam int OCT_W    = 3;
  localparam int NOTE_MAX = 127;
  localparam int QDEPTH   = 4;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_NOTE_ON  = 2'd0;
  localparam cfg_idx_t CFG_NOTE_OFF = 2'd1;
  localparam cfg_idx_t CFG_VELOCITY = 2'd2;
  localparam cfg_idx_t CFG_OCTAVE   = 2'd3;

  localparam logic [BYTE_W-1:0] NOTE_ON_RST  = 8'd144;
  localparam logic [BYTE_W-1:0] NOTE_OFF_RST = 8'd128;
  localparam logic [VEL_W-1:0]  VELOCITY_RST = 7'd64;
  localparam logic [OCT_W-1:0]  OCTAVE_RST   = 3'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] note_on;
    logic [BYTE_W-1:0] note_off;
    logic [VEL_W-1:0]  velocity;
    logic [OCT_W-1:0]  octave;
  } kmne_cfg_t;

  // one column sample that changed at least one key
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_MAX-1:0] change;
    logic [ROW_MAX-1:0] now;
  } kmne_evt_t;

  // column + (row + octave) * 12, clipped to the data byte range
  function automatic logic [BYTE_W-1:0] note_number(logic [COL_W-1:0] col,
                                                    logic [2:0] row,
                                                    logic [OCT_W-1:0] oct);
    logic [3:0] oc;
    logic [8:0] sum;
    oc  = {1'b0, row} + {1'b0, oct};
    // times twelve as times eight plus times four
    sum = {2'b00, oc, 3'b000} + {3'b000, oc, 2'b00} + {5'b00000, col};
    return (sum > 9'(NOTE_MAX)) ? BYTE_W'(NOTE_MAX) : sum[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/key_matrix_midi_note_events.sv
// top level: key matrix column samples in, MIDI note message bytes out
// a changed sample is queued, then loaded by the sequencer, which registers its bytes
// throughput: a sample is taken every cycle while the 4-entry change queue has room;
// the byte sequencer loads each changed sample, then sends three bytes per changed key
// reset: key state all released, registers to their defaults, queue and output empty;
// no clearing pass, the block takes items right after reset
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_midi_note_events
  import kmne_pkg::*;
#(
  parameter int COLUMNS = 13,
  parameter int ROWS    = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [BYTE_W-1:0]  cfg_wdata,
  input  wire                in_push,
  input  wire  [COL_W-1:0]   in_column,
  input  wire  [SENSE_W-1:0] in_row_sense,
  output logic               in_full,
  output logic               out_empty,
  input  wire                out_pop,
  output logic [BYTE_W-1:0]  out_midi_byte,
  output logic               out_last_of_run
);

  kmne_cfg_t cfg_r;
  kmne_evt_t evt;
  kmne_evt_t q_data;
  logic      evt_push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.note_on  <= NOTE_ON_RST;
      cfg_r.note_off <= NOTE_OFF_RST;
      cfg_r.velocity <= VELOCITY_RST;
      cfg_r.octave   <= OCTAVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NOTE_ON:  cfg_r.note_on  <= cfg_wdata;
        CFG_NOTE_OFF: cfg_r.note_off <= cfg_wdata;
        CFG_VELOCITY: cfg_r.velocity <= cfg_wdata[VEL_W-1:0];
        CFG_OCTAVE:   cfg_r.octave   <= cfg_wdata[OCT_W-1:0];
        default:      cfg_r.octave   <= cfg_r.octave;
      endcase
    end
  end

  kmne_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_column    (in_column),
    .in_row_sense (in_row_sense),
    .in_full      (in_full),
    .q_full       (q_full),
    .evt_push     (evt_push),
    .evt          (evt)
  );

  kmne_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (evt_push),
    .din   (evt),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_data)
  );

  kmne_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_midi_byte   (out_midi_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// File: hdl/kmne_front.sv
// front end: key state per column and change detection for each column sample
`timescale 1ns / 1ps
`default_nettype none

module kmne_front
  import kmne_pkg::*;
#(
  parameter int COLUMNS = 13,
  parameter int ROWS    = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  input  wire  [COL_W-1:0]   in_column,
  input  wire  [SENSE_W-1:0] in_row_sense,
  output logic               in_full,
  input  wire                q_full,
  output logic               evt_push,
  output kmne_evt_t          evt
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [ROWS-1:0]         key_r [COLUMNS];
  logic [ROWS+SENSE_W-1:0] sense_ext;
  logic [ROWS-1:0]         now;
  logic [ROWS-1:0]         was;
  logic [ROWS-1:0]         change;
  logic [CW-1:0]           col_idx;
  logic                    in_range;
  logic                    accept;

  // rows past the sense width always read as released
  assign sense_ext = {{ROWS{1'b0}}, in_row_sense};
  assign now       = sense_ext[ROWS-1:0];
  assign in_range  = {1'b0, in_column} < 5'(COLUMNS);
  assign col_idx   = in_column[CW-1:0];
  assign was       = in_range ? key_r[col_idx] : '0;
  assign change    = now ^ was;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign evt_push = accept && in_range && (|change);

  assign evt.column = in_column;
  assign evt.change = ROW_MAX'(change);
  assign evt.now    = ROW_MAX'(now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) begin
        key_r[c] <= '0;
      end
    end else if (accept && in_range) begin
      key_r[col_idx] <= now;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kmne_queue.sv
// short event queue between the change detector and the byte sequencer
`timescale 1ns / 1ps
`default_nettype none

module kmne_queue
  import kmne_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  kmne_evt_t  din,
  output logic       full,
  input  wire        pop,
  output logic       valid,
  output kmne_evt_t  dout
);

  localparam int PW = $clog2(QDEPTH);

  kmne_evt_t     mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = count_r == (PW+1)'(QDEPTH);
  assign valid   = count_r != '0;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/kmne_back.sv
// back end: turns each queued change set into note messages, one byte per beat
`timescale 1ns / 1ps
`default_nettype none

module kmne_back
  import kmne_pkg::*;
#(
  parameter int ROWS = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  kmne_cfg_t         cfg,
  input  wire               q_valid,
  input  kmne_evt_t         q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  wire               out_pop,
  output logic [BYTE_W-1:0] out_midi_byte,
  output logic              out_last_of_run
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {PH_STATUS, PH_NOTE, PH_VEL} phase_t;

  phase_t            phase_r;
  logic              busy_r;
  logic [COL_W-1:0]  col_r;
  logic [ROWS-1:0]   mask_r;
  logic [ROWS-1:0]   now_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [RW-1:0]     sel;
  logic              found;
  logic [ROWS-1:0]   mask_nxt;
  logic [BYTE_W-1:0] byte_nxt;
  logic              adv;

  // lowest row still waiting in this column
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      if (mask_r[r] && !found) begin
        sel   = RW'(r);
        found = 1'b1;
      end
    end
  end

  assign mask_nxt = mask_r & ~(ROWS'(1) << sel);

  always_comb begin
    unique case (phase_r)
      PH_STATUS: byte_nxt = now_r[sel] ? cfg.note_on : cfg.note_off;
      PH_NOTE:   byte_nxt = note_number(col_r, 3'(sel), cfg.octave);
      PH_VEL:    byte_nxt = {1'b0, cfg.velocity};
      default:   byte_nxt = '0;
    endcase
  end

  // output slot is free or is being taken this beat
  assign adv   = !out_valid_r || out_pop;
  assign q_pop = !busy_r && q_valid;

  assign out_empty       = !out_valid_r;
  assign out_midi_byte   = out_byte_r;
  assign out_last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STATUS;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        if (q_valid) begin
          busy_r  <= 1'b1;
          phase_r <= PH_STATUS;
          col_r   <= q_data.column;
          mask_r  <= q_data.change[ROWS-1:0];
          now_r   <= q_data.now[ROWS-1:0];
        end
      end else if (adv) begin
        out_byte_r <= byte_nxt;
        out_last_r <= 1'b0;
        unique case (phase_r)
          PH_STATUS: phase_r <= PH_NOTE;
          PH_NOTE:   phase_r <= PH_VEL;
          PH_VEL: begin
            phase_r    <= PH_STATUS;
            mask_r     <= mask_nxt;
            out_last_r <= mask_nxt == '0;
            if (mask_nxt == '0) begin
              busy_r <= 1'b0;
            end
          end
          default:   phase_r <= PH_STATUS;
        endcase
      end
      priority if (busy_r && adv) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/kmne_checker.sv
// port-level checker for the key matrix note event block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "key_matrix_midi_note_events_macros.svh"

module kmne_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_full,
  input wire       out_empty,
  input wire       out_pop,
  input wire [7:0] out_midi_byte,
  input wire       out_last_of_run
);

  // both sides come out of reset idle and able to take a beat
  `KMNE_CHK_RST(a_reset_idle, out_empty && !in_full, "not idle after reset")

  // a waiting result beat holds until taken
  `KMNE_CHK_NXT(a_out_hold, !out_empty && !out_pop,
                !out_empty && $stable(out_midi_byte) && $stable(out_last_of_run),
                "result beat changed while stalled")

  // the run always ends on a velocity byte, which is a data byte
  `KMNE_CHK_IMP(a_last_is_data, !out_empty && out_last_of_run, !out_midi_byte[7],
                "last beat of a run is not a data byte")

endmodule

bind key_matrix_midi_note_events kmne_checker u_kmne_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the key matrix note event block: directed table, then random column samples
`timescale 1ns / 1ps

module tb_top;
  import kmne_pkg::*;

  localparam int NCOL          = 13;
  localparam int NROW          = 4;
  localparam int NOTES_PER_OCT = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 58;
  localparam int HOLD_CYCLES   = 250;
  localparam int IDLE_PCT      = 27;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } midi_beat_t;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [SENSE_W-1:0] sense;
    logic               typed;
    logic [3:0]         nbeats;
    logic [BYTE_W-1:0]  b0;
    logic [BYTE_W-1:0]  b1;
    logic [BYTE_W-1:0]  b2;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [BYTE_W-1:0]  cfg_wdata;
  logic               in_push;
  logic [COL_W-1:0]   in_column;
  logic [SENSE_W-1:0] in_row_sense;
  logic               in_full;
  logic               out_empty;
  logic               out_pop;
  logic [BYTE_W-1:0]  out_midi_byte;
  logic               out_last_of_run;

  key_matrix_midi_note_events #(
    .COLUMNS(NCOL),
    .ROWS   (NROW)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_column      (in_column),
    .in_row_sense   (in_row_sense),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_midi_byte  (out_midi_byte),
    .out_last_of_run(out_last_of_run)
  );

  // shadow of the key state and the registers
  logic [SENSE_W-1:0] keys_down [NCOL];
  logic [BYTE_W-1:0]  sh_note_on;
  logic [BYTE_W-1:0]  sh_note_off;
  logic [VEL_W-1:0]   sh_velocity;
  logic [OCT_W-1:0]   sh_octave;

  midi_beat_t beats_due [$];
  midi_beat_t new_beats [$];
  int         errors;
  int         cycles;
  bit         idle_on;
  int         hold_requests;

  // defaults: on 144, off 128, velocity 64, octave 3
  stim_row_t dir_rows [18] = '{
    '{4'd0,  4'b0001, 1'b1, 4'd3, 8'd144, 8'd36, 8'd64},
    '{4'd0,  4'b0000, 1'b1, 4'd3, 8'd128, 8'd36, 8'd64},
    '{4'd12, 4'b1000, 1'b1, 4'd3, 8'd144, 8'd84, 8'd64},
    '{4'd12, 4'b1000, 1'b1, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd13, 4'b1111, 1'b1, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd15, 4'b1111, 1'b1, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd12, 4'b0111, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd5,  4'b1111, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd5,  4'b0000, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd7,  4'b1010, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd7,  4'b0101, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd14, 4'b0000, 1'b1, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd1,  4'b0100, 1'b1, 4'd3, 8'd144, 8'd61, 8'd64},
    '{4'd1,  4'b0000, 1'b1, 4'd3, 8'd128, 8'd61, 8'd64},
    '{4'd11, 4'b1111, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd11, 4'b1111, 1'b1, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd0,  4'b1111, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0},
    '{4'd12, 4'b0000, 1'b0, 4'd0, 8'd0,   8'd0,  8'd0}
  };

  // note messages one column sample causes, left in new_beats
  function automatic void predict_column(input logic [COL_W-1:0] col,
                                         input logic [SENSE_W-1:0] sense);
    int note;
    bit now_down;
    bit was_down;
    new_beats.delete();
    if (int'(col) >= NCOL) return;
    for (int r = 0; r < NROW; r++) begin
      now_down = sense[r];
      was_down = keys_down[col][r];
      if (now_down != was_down) begin
        keys_down[col][r] = now_down;
        note = int'(col) + (r + int'(sh_octave)) * NOTES_PER_OCT;
        if (note > NOTE_MAX) note = NOTE_MAX;
        new_beats.push_back('{now_down ? sh_note_on : sh_note_off, 1'b0});
        new_beats.push_back('{BYTE_W'(note), 1'b0});
        new_beats.push_back('{{1'b0, sh_velocity}, 1'b0});
      end
    end
    if (new_beats.size() > 0) new_beats[new_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic send_sample(input stim_row_t row);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_column    <= row.col;
    in_row_sense <= row.sense;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_column(row.col, row.sense);
    if (row.typed) begin
      if (row.nbeats == 4'd3) begin
        beats_due.push_back('{row.b0, 1'b0});
        beats_due.push_back('{row.b1, 1'b0});
        beats_due.push_back('{row.b2, 1'b1});
      end
    end else begin
      foreach (new_beats[i]) beats_due.push_back(new_beats[i]);
    end
    @(negedge clk);
  endtask

  // called at a falling edge; leaves the block idle
  task automatic wait_drained();
    in_push <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] on_st, input logic [BYTE_W-1:0] off_st,
                          input logic [VEL_W-1:0] vel, input logic [OCT_W-1:0] oct);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NOTE_ON;
    cfg_wdata <= on_st;
    @(negedge clk);
    cfg_index <= CFG_NOTE_OFF;
    cfg_wdata <= off_st;
    @(negedge clk);
    cfg_index <= CFG_VELOCITY;
    cfg_wdata <= {1'b0, vel};
    @(negedge clk);
    cfg_index <= CFG_OCTAVE;
    cfg_wdata <= BYTE_W'(oct);
    @(negedge clk);
    cfg_we      <= 1'b0;
    sh_note_on  = on_st;
    sh_note_off = off_st;
    sh_velocity = vel;
    sh_octave   = oct;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** key_matrix_midi_note_events: FAILED **");
      $finish;
    end
  end

  // result side
  initial begin
    int hold_left;
    int holds_seen;
    midi_beat_t want;
    hold_left  = 0;
    holds_seen = 0;
    errors     = 0;
    out_pop    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (beats_due.size() == 0) begin
          $display("%0t: beat with nothing expected: byte %h last %b",
                   $time, out_midi_byte, out_last_of_run);
          errors++;
        end else begin
          want = beats_due.pop_front();
          if (out_midi_byte !== want.data) begin
            $display("%0t: midi_byte expected %h actual %h", $time, want.data, out_midi_byte);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %b actual %b",
                     $time, want.last, out_last_of_run);
            errors++;
          end
        end
      end
    end
  end

  // sample side and phase sequencing
  initial begin
    stim_row_t row;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_NOTE_ON;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_column     = '0;
    in_row_sense  = '0;
    idle_on       = 1'b1;
    hold_requests = 0;
    sh_note_on    = NOTE_ON_RST;
    sh_note_off   = NOTE_OFF_RST;
    sh_velocity   = VELOCITY_RST;
    sh_octave     = OCTAVE_RST;
    foreach (keys_down[c]) keys_down[c] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_sample(dir_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: set_regs(8'd128, 8'd255, 7'd0, 3'd0);
        1: set_regs(8'd255, 8'd128, 7'd127, 3'd6);
        // top octave pushes high notes past the data byte range
        2: set_regs(8'd200, 8'd137, 7'd85, 3'd7);
        default: set_regs(BYTE_W'($urandom_range(255, 128)), BYTE_W'($urandom_range(255, 128)),
                          VEL_W'($urandom_range(127)), OCT_W'($urandom_range(6)));
      endcase
      idle_on = (p != 3);
      if (p == 1) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        row       = '0;
        row.col   = ($urandom_range(9) == 0) ? COL_W'($urandom_range(15, 13))
                                             : COL_W'($urandom_range(12));
        row.sense = SENSE_W'($urandom_range(15));
        send_sample(row);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("** key_matrix_midi_note_events: PASSED **");
    end else begin
      $display("** key_matrix_midi_note_events: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/kmne_pkg.sv
hdl/kmne_front.sv
hdl/kmne_queue.sv
hdl/kmne_back.sv
hdl/key_matrix_midi_note_events.sv
hdl/kmne_checker.sv
tb/tb_top.sv
